>>> rtl/hse_pkg.sv
// Shared constants for the heap sort engine: store depth and derived widths.
// Used by heap_sort_engine_core; no dependencies.
package hse_pkg;

   localparam int DEPTH  = 16;                   // entries in the element store, 2..64
   localparam int DATA_W = 32;                   // element width
   localparam int IDX_W  = $clog2(DEPTH);        // store address width
   localparam int CNT_W  = $clog2(DEPTH + 1);    // element count, holds DEPTH itself
   localparam int CH_W   = IDX_W + 2;            // child index, up to 2*(DEPTH-1)+2

endpackage

>>> rtl/heap_sort_engine_core.sv
// Heap sort engine top level: loads a set into a RAM, heap-sorts it in place, streams it out.
// Depends on hse_pkg (constants) and hse_ram (element store).
//
//   channel | direction | tdata                   | tlast
//   req_    | in        | [31:0] value            | last
//   rsp_    | out       | [31:0] sorted_value     | last_res
//
// Loading writes each accepted item into the store. Sorting is one sift-down per inner
// node, then one root extraction per element but one; each heap level reads both children
// through the single RAM read port, then compares and writes back, and each extraction
// reads the root and the heap end first. Each result is read once the output register
// is free, then loaded into it. Reset is synchronous and clears the control state only.
// A stalled result holds the output register; loading of the next set may start under it.
module heap_sort_engine_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] value
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] sorted_value
   output logic        rsp_tlast
);

   localparam logic [3:0] ST_LOAD   = 4'd0;
   localparam logic [3:0] ST_BUILD  = 4'd1;
   localparam logic [3:0] ST_SD_CAP = 4'd2;
   localparam logic [3:0] ST_RD_L   = 4'd3;
   localparam logic [3:0] ST_RD_R   = 4'd4;
   localparam logic [3:0] ST_CMP    = 4'd5;
   localparam logic [3:0] ST_EXT    = 4'd6;
   localparam logic [3:0] ST_EX1    = 4'd7;
   localparam logic [3:0] ST_EX2    = 4'd8;
   localparam logic [3:0] ST_E_RD   = 4'd9;
   localparam logic [3:0] ST_E_OUT  = 4'd10;

   logic [3:0]                     state_ff, state_in;
   logic [hse_pkg::CNT_W-1:0]      count_ff, count_in;     // fill count, then set length
   logic [hse_pkg::CNT_W-1:0]      k_ff, k_in;             // build node / extraction end
   logic [hse_pkg::CNT_W-1:0]      heap_len_ff, heap_len_in;
   logic [hse_pkg::IDX_W-1:0]      node_ff, node_in;       // sift position, or emit index
   logic                           build_ff, build_in;
   logic [hse_pkg::DATA_W-1:0]     cur_ff, cur_in;         // value being sifted down
   logic [hse_pkg::DATA_W-1:0]     lval_ff, lval_in;       // left child, or old root
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [hse_pkg::DATA_W-1:0]     rsp_data_ff, rsp_data_in;
   logic                           rsp_last_ff, rsp_last_in;

   logic                           wr_en, rd_en;
   logic [hse_pkg::IDX_W-1:0]      wr_addr, rd_addr;
   logic [hse_pkg::DATA_W-1:0]     wr_data, rd_data;

   logic [hse_pkg::CH_W-1:0]       lc, rc, len_ext;
   logic [hse_pkg::CNT_W-1:0]      len_new;
   logic                           in_accept, out_free, l_wins, r_wins;
   logic [hse_pkg::DATA_W-1:0]     top_val;

   hse_ram #(
      .WIDTH (hse_pkg::DATA_W),
      .DEPTH (hse_pkg::DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign req_tready = (state_ff == ST_LOAD);
   assign in_accept  = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign lc      = {1'b0, node_ff, 1'b1};
   assign rc      = {node_ff, 1'b0} + hse_pkg::CH_W'(2);
   assign len_ext = hse_pkg::CH_W'(heap_len_ff);
   assign len_new = count_ff + hse_pkg::CNT_W'(1);

   // The sifted value stays in a register; the store entry at the sift position is a hole
   // until the final write, which leaves the same contents as swapping level by level.
   assign l_wins  = $signed(lval_ff) > $signed(cur_ff);
   assign top_val = l_wins ? lval_ff : cur_ff;
   assign r_wins  = (rc < len_ext) && ($signed(rd_data) > $signed(top_val));

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      k_in         = k_ff;
      heap_len_in  = heap_len_ff;
      node_in      = node_ff;
      build_in     = build_ff;
      cur_in       = cur_ff;
      lval_in      = lval_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      wr_en        = 1'b0;
      wr_addr      = node_ff;
      wr_data      = cur_ff;
      rd_en        = 1'b0;
      rd_addr      = node_ff;

      case (state_ff)
         ST_LOAD: begin
            if (in_accept) begin
               wr_en   = 1'b1;
               wr_addr = count_ff[hse_pkg::IDX_W-1:0];
               wr_data = req_tdata;
               count_in = len_new;
               // A full store closes the set as if the last flag were set.
               if (req_tlast || count_ff == hse_pkg::CNT_W'(hse_pkg::DEPTH - 1)) begin
                  k_in        = len_new >> 1;
                  heap_len_in = len_new;
                  build_in    = 1'b1;
                  state_in    = ST_BUILD;
               end
            end
         end
         ST_BUILD: begin
            if (k_ff == '0) begin
               k_in     = count_ff - hse_pkg::CNT_W'(1);
               build_in = 1'b0;
               state_in = ST_EXT;
            end else begin
               node_in  = k_ff[hse_pkg::IDX_W-1:0] - hse_pkg::IDX_W'(1);
               rd_en    = 1'b1;
               rd_addr  = k_ff[hse_pkg::IDX_W-1:0] - hse_pkg::IDX_W'(1);
               k_in     = k_ff - hse_pkg::CNT_W'(1);
               state_in = ST_SD_CAP;
            end
         end
         ST_SD_CAP: begin
            cur_in   = rd_data;
            state_in = ST_RD_L;
         end
         ST_RD_L: begin
            if (lc < len_ext) begin
               rd_en    = 1'b1;
               rd_addr  = lc[hse_pkg::IDX_W-1:0];
               state_in = ST_RD_R;
            end else begin
               wr_en    = 1'b1;
               state_in = build_ff ? ST_BUILD : ST_EXT;
            end
         end
         ST_RD_R: begin
            lval_in  = rd_data;
            rd_en    = 1'b1;
            rd_addr  = rc[hse_pkg::IDX_W-1:0];
            state_in = ST_CMP;
         end
         ST_CMP: begin
            wr_en = 1'b1;
            if (r_wins) begin
               wr_data  = rd_data;
               node_in  = rc[hse_pkg::IDX_W-1:0];
               state_in = ST_RD_L;
            end else if (l_wins) begin
               wr_data  = lval_ff;
               node_in  = lc[hse_pkg::IDX_W-1:0];
               state_in = ST_RD_L;
            end else begin
               wr_data  = cur_ff;
               state_in = build_ff ? ST_BUILD : ST_EXT;
            end
         end
         ST_EXT: begin
            if (k_ff == '0) begin
               node_in  = '0;
               state_in = ST_E_RD;
            end else begin
               rd_en    = 1'b1;
               rd_addr  = '0;
               state_in = ST_EX1;
            end
         end
         ST_EX1: begin
            lval_in  = rd_data;
            rd_en    = 1'b1;
            rd_addr  = k_ff[hse_pkg::IDX_W-1:0];
            state_in = ST_EX2;
         end
         ST_EX2: begin
            // The old root goes to the end of the heap; the end value sifts down from the root.
            wr_en       = 1'b1;
            wr_addr     = k_ff[hse_pkg::IDX_W-1:0];
            wr_data     = lval_ff;
            cur_in      = rd_data;
            heap_len_in = k_ff;
            node_in     = '0;
            k_in        = k_ff - hse_pkg::CNT_W'(1);
            state_in    = ST_RD_L;
         end
         ST_E_RD: begin
            if (out_free) begin
               rd_en    = 1'b1;
               rd_addr  = node_ff;
               state_in = ST_E_OUT;
            end
         end
         ST_E_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = rd_data;
            rsp_last_in  = (hse_pkg::CNT_W'(node_ff) == count_ff - hse_pkg::CNT_W'(1));
            if (hse_pkg::CNT_W'(node_ff) == count_ff - hse_pkg::CNT_W'(1)) begin
               count_in = '0;
               state_in = ST_LOAD;
            end else begin
               node_in  = node_ff + hse_pkg::IDX_W'(1);
               state_in = ST_E_RD;
            end
         end
         default: begin
            state_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_LOAD;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      k_ff        <= k_in;
      heap_len_ff <= heap_len_in;
      node_ff     <= node_in;
      build_ff    <= build_in;
      cur_ff      <= cur_in;
      lval_ff     <= lval_in;
      rsp_data_ff <= rsp_data_in;
      rsp_last_ff <= rsp_last_in;
   end

   // A set being sorted or emitted is never empty.
   a_len_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_LOAD |-> count_ff != '0)
      else $error("set length is zero outside loading");

   // Sorting never writes outside the loaded set.
   a_wr_in_set: assert property (@(posedge clock) disable iff (reset)
      (wr_en && state_ff != ST_LOAD) |-> hse_pkg::CNT_W'(wr_addr) < count_ff)
      else $error("store write beyond the loaded set");

   // The sift position stays inside the current heap.
   a_node_in_heap: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CMP || state_ff == ST_RD_R) |-> hse_pkg::CNT_W'(node_ff) < heap_len_ff)
      else $error("sift position outside heap");

   // A result is only loaded into a free output register.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_E_OUT |-> $past(out_free))
      else $error("output register overwritten");

endmodule

>>> rtl/hse_ram.sv
// Generic single-clock RAM: one write port, one read port with registered read data.
// No dependencies; instantiated by heap_sort_engine_core.
module hse_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

>>> test/heap_sort_engine_core_test.sv
// Self-checking testbench for heap_sort_engine_core: streams sets of signed values in and
// checks that each set comes back in ascending order with the final value marked.
// Depends on hse_pkg (DEPTH, DATA_W) and on the RTL of heap_sort_engine_core.
module heap_sort_engine_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RANDOM_ITEMS = 250;
   localparam int IDLE_LIMIT   = 6000;
   localparam int TAIL_CYCLES  = 300;

   typedef logic signed [hse_pkg::DATA_W-1:0] elem_type;

   typedef struct {
      elem_type value;
      logic     last;
      int       gap;
      bit       drain;
   } req_item_type;

   typedef struct {
      elem_type value;
      logic     last;
   } sorted_elem_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;      // [31:0] value
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;          // [31:0] sorted_value
   logic        rsp_tlast;

   req_item_type    pending_items[$];
   elem_type        open_set[$];
   sorted_elem_type sorted_expect[$];

   // Driver and monitor working state.
   req_item_type cur_item;
   bit        staged = 1'b0;
   int        gap_left;
   logic      valid_next;
   int        stall_left = 0;
   bit        rx_burst = 1'b0;
   logic      ready_next;
   int        idle_cycles = 0;

   int fail_count    = 0;
   int items_sent    = 0;
   int sets_closed   = 0;
   int sets_full     = 0;
   int results_seen  = 0;

   heap_sort_engine_core uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic queue_item(input elem_type value, input logic last, input int gap,
                             input bit drain);
      req_item_type it;
      it.value = value;
      it.last  = last;
      it.gap   = gap;
      it.drain = drain;
      pending_items.push_back(it);
   endtask

   // Stores an accepted value into the open set; a last flag or a full store closes
   // the set, which is then sorted ascending and queued as expected results.
   task automatic store_and_sort(input elem_type value, input logic last);
      elem_type        sorted[$];
      elem_type        tmp;
      sorted_elem_type res;
      int              j;
      open_set.push_back(value);
      items_sent++;
      if (last || open_set.size() == hse_pkg::DEPTH) begin
         if (!last) begin
            sets_full++;
         end
         sorted = open_set;
         for (int i = 1; i < sorted.size(); i++) begin
            tmp = sorted[i];
            j = i - 1;
            while (j >= 0 && sorted[j] > tmp) begin
               sorted[j + 1] = sorted[j];
               j--;
            end
            sorted[j + 1] = tmp;
         end
         for (int i = 0; i < sorted.size(); i++) begin
            res.value = sorted[i];
            res.last  = (i == sorted.size() - 1);
            sorted_expect.push_back(res);
         end
         open_set.delete();
         sets_closed++;
      end
   endtask

   function automatic elem_type pick_value(input int mode);
      elem_type corner[7];
      corner[0] = 32'sh8000_0000;
      corner[1] = 32'sh7FFF_FFFF;
      corner[2] = 0;
      corner[3] = -1;
      corner[4] = 1;
      corner[5] = 32'sh8000_0001;
      corner[6] = 32'sh7FFF_FFFE;
      case (mode)
         0: begin
            return elem_type'($urandom);
         end
         1: begin
            return elem_type'($signed($urandom_range(0, 6)) - 3);
         end
         default: begin
            return corner[$urandom_range(0, 6)];
         end
      endcase
   endfunction

   // Driver: one item at a time from the pending queue, each after its own gap.
   always @(posedge clock) begin
      if (reset) begin
         valid_next = 1'b0;
      end else begin
         valid_next = req_tvalid;
         if (req_tvalid && req_tready) begin
            store_and_sort(req_tdata, req_tlast);
            valid_next = 1'b0;
         end
         if (!valid_next) begin
            if (!staged && pending_items.size() != 0) begin
               cur_item = pending_items.pop_front();
               gap_left = cur_item.gap;
               staged   = 1'b1;
            end
            if (staged) begin
               if (cur_item.drain && sorted_expect.size() != 0) begin
                  // Hold the item back until every sorted value has come out.
               end else if (gap_left > 0) begin
                  gap_left--;
               end else begin
                  valid_next = 1'b1;
                  req_tdata <= cur_item.value;
                  req_tlast <= cur_item.last;
                  staged     = 1'b0;
               end
            end
         end
      end
      req_tvalid <= valid_next;
   end

   // Monitor: checks each result transaction and stalls at random after it.
   always @(posedge clock) begin
      if (reset) begin
         ready_next = 1'b0;
      end else begin
         ready_next = rsp_tready;
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (sorted_expect.size() == 0) begin
               $display("%0t: unexpected result: value %0d last %0b", $time,
                        $signed(rsp_tdata), rsp_tlast);
               fail_count++;
            end else begin
               if (rsp_tdata !== sorted_expect[0].value) begin
                  $display("%0t: sorted_value mismatch: expected %0d, actual %0d", $time,
                           sorted_expect[0].value, $signed(rsp_tdata));
                  fail_count++;
               end
               if (rsp_tlast !== sorted_expect[0].last) begin
                  $display("%0t: last_res mismatch: expected %0b, actual %0b", $time,
                           sorted_expect[0].last, rsp_tlast);
                  fail_count++;
               end
               void'(sorted_expect.pop_front());
            end
            if ($urandom_range(0, 19) == 0) begin
               rx_burst = !rx_burst;
            end
            stall_left = rx_burst ? 0 : $urandom_range(0, 19);
            ready_next = (stall_left == 0);
         end else if (!rsp_tready) begin
            if (stall_left > 0) begin
               stall_left--;
            end
            if (stall_left == 0) begin
               ready_next = 1'b1;
            end
         end
      end
      rsp_tready <= ready_next;
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
         $display("heap_sort_engine_core test failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int  count;
      int  kind;
      int  len;
      int  mode;
      int  flagged_at;
      bit  tx_burst;
      bit  first_random;

      // Directed: single-element sets at both extremes, a short pair, then a run of
      // corner and small values with repeats and no last flag, so the full store closes it.
      queue_item(32'sh7FFF_FFFF, 1'b1, 0, 1'b0);
      queue_item(32'sh8000_0000, 1'b1, 3, 1'b0);
      queue_item(0, 1'b0, 0, 1'b0);
      queue_item(-1, 1'b1, 0, 1'b0);
      for (int i = 0; i < hse_pkg::DEPTH; i++) begin
         queue_item(pick_value(i % 3 == 0 ? 1 : 2), 1'b0, i % 4, 1'b0);
      end

      count = 0;
      first_random = 1'b1;
      while (count < RANDOM_ITEMS) begin
         kind     = $urandom_range(0, 9);
         mode     = $urandom_range(0, 2);
         tx_burst = ($urandom_range(0, 3) == 0);
         flagged_at = -1;
         case (kind)
            0: begin
               len = hse_pkg::DEPTH;
               flagged_at = hse_pkg::DEPTH - 1;
            end
            1: begin
               // Overrun: the store fills first, the rest spills into the next set.
               len = hse_pkg::DEPTH + $urandom_range(1, 4);
               flagged_at = len - 1;
            end
            2, 3, 4: begin
               len = $urandom_range(1, 3);
               flagged_at = len - 1;
            end
            default: begin
               len = $urandom_range(1, 8);
               flagged_at = len - 1;
            end
         endcase
         for (int i = 0; i < len; i++) begin
            queue_item(pick_value(mode), (i == flagged_at), tx_burst ? 0 : $urandom_range(0, 19),
                       first_random);
            first_random = 1'b0;
         end
         count += len;
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (pending_items.size() != 0 || staged || req_tvalid || sorted_expect.size() != 0) begin
         @(posedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);

      if (open_set.size() != 0) begin
         $display("%0t: %0d values left in an unclosed set", $time, open_set.size());
         fail_count++;
      end
      if (sorted_expect.size() != 0) begin
         $display("%0t: %0d expected results never arrived", $time, sorted_expect.size());
         fail_count++;
      end
      $display("Sent %0d values in %0d sets, %0d of them closed by a full store;",
               items_sent, sets_closed, sets_full);
      $display("checked %0d sorted results with %0d mismatches.", results_seen, fail_count);
      if (fail_count == 0) begin
         $display("heap_sort_engine_core test passed");
      end else begin
         $display("heap_sort_engine_core test failed");
      end
      $finish;
   end

endmodule
